FILE: src/crb_pkg.sv
// shared constants, types and codes of the chunk reception bitmap
package crb_pkg;

   localparam int MAP_ENTRIES = 1024;
   localparam int KB_PER_ENTRY = 8;
   localparam int MASK_W = KB_PER_ENTRY;
   localparam int BIT_W = $clog2(KB_PER_ENTRY);
   localparam int ADDR_W = $clog2(MAP_ENTRIES);
   localparam int CNT_W = ADDR_W + 1;
   localparam int KB_W = ADDR_W + BIT_W;
   localparam int CSR_W = 14;
   localparam int CAP_KB = MAP_ENTRIES * KB_PER_ENTRY;
   localparam int CMD_W = 2;

   localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RECV = 2'd2;

   localparam logic [MASK_W-1:0] FULL_ENTRY = 8'hff;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RMW  = 4'b0010,
      ST_INIT = 4'b0100,
      ST_SCAN = 4'b1000
   } crb_state_type;

   typedef struct packed {
      logic              ok;
      logic [BIT_W-1:0]  bit_sel;
      logic [MASK_W-1:0] new_val;
      logic              now_zero;
   } crb_rmw_type;

endpackage

FILE: src/chunk_reception_bitmap_top.sv
// chunk reception bitmap: pending map memory, init sweep, query scan, receive update
//
// tracks which 1 KB chunks of a transfer are still missing, one 8-bit pending
// mask per 8 KB map entry, held in a single-port-write synchronous memory
// channels: req_ word (cmd, entry_index, chunk_mask) in, rsp_ word out, one
// rsp_ word per req_ word, in order; csr_ writes the transfer size in KB and
// is always ready (write it only while the block is idle)
// receive: memory read, then modify and write back
// query: memory read at the scan pointer, then one per empty map entry skipped,
//   one memory read per cycle; a map with nothing pending answers without a scan
// init: one memory write per map entry, none for an empty map, up to
//   1024 for a full map
// unused command: no state change
// one word is worked at a time; req_ready is high whenever no word is in work,
// also while a finished rsp_ word is held; a stalled receiver holds the
// block at the end of the next word until rsp_ is taken
// reset clears the pointers and counters; the map memory is not cleared,
// entries are only used once an init has written them
module chunk_reception_bitmap_top
   import crb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_W-1:0]    csr_total_kbytes,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [ADDR_W-1:0]   req_entry_index,
   input  logic [MASK_W-1:0]   req_chunk_mask,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_hit,
   output logic [ADDR_W-1:0]   rsp_chosen_entry,
   output logic [MASK_W-1:0]   rsp_pending_mask,
   output logic [KB_W-1:0]     rsp_write_kb_index,
   output logic                rsp_all_done
);

   logic [MASK_W-1:0] map_mem [MAP_ENTRIES];
   logic [MASK_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [MASK_W-1:0] mem_wd;

   crb_state_type     state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [CSR_W-1:0]  total_kb_ff;
   logic [CNT_W-1:0]  entries_ff, entries_in;
   logic [CNT_W-1:0]  nonzero_ff, nonzero_in;
   logic [ADDR_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic [CNT_W-1:0]  fill_ptr_ff, fill_ptr_in;
   logic [ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic [ADDR_W-1:0] data_addr_ff, data_addr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              hit_ff, hit_in;
   logic [ADDR_W-1:0] chosen_ff, chosen_in;
   logic [MASK_W-1:0] pmask_ff, pmask_in;
   logic [KB_W-1:0]   kbidx_ff, kbidx_in;
   logic              done_ff, done_in;

   logic              finish;
   logic              out_free;
   logic              accept;
   logic [CSR_W-1:0]  kb_clamped;
   logic [CNT_W-1:0]  full_cnt;
   logic [BIT_W-1:0]  rem_kb;
   logic [CNT_W-1:0]  new_entries;
   logic [MASK_W-1:0] part_val;
   logic [ADDR_W-1:0] start_pos;
   logic              in_range;
   logic              fill_last;
   crb_rmw_type       rmw;

   function automatic logic [ADDR_W-1:0] next_addr(input logic [ADDR_W-1:0] a,
                                                   input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] inc;
      inc = {1'b0, a} + CNT_W'(1);
      return (inc >= n) ? '0 : inc[ADDR_W-1:0];
   endfunction

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign kb_clamped = (int'(total_kb_ff) > CAP_KB) ? CSR_W'(CAP_KB) : total_kb_ff;
   assign full_cnt = CNT_W'(kb_clamped >> BIT_W);
   assign rem_kb = kb_clamped[BIT_W-1:0];
   assign new_entries = full_cnt + CNT_W'(rem_kb != '0);
   assign part_val = MASK_W'((9'd1 << rem_kb) - 9'd1);
   assign start_pos = ({1'b0, scan_ptr_ff} < entries_ff) ? scan_ptr_ff : '0;
   assign in_range = ({1'b0, idx_ff} < entries_ff);
   assign fill_last = (new_entries == '0) || (fill_ptr_ff + CNT_W'(1) == new_entries);

   crb_rmw_unit u_rmw (
      .enable     (in_range && (cmd_ff == CMD_RECV)),
      .cur_val    (rd_data_ff),
      .chunk_mask (mask_ff),
      .result     (rmw)
   );

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      mask_in = mask_ff;
      entries_in = entries_ff;
      nonzero_in = nonzero_ff;
      scan_ptr_in = scan_ptr_ff;
      fill_ptr_in = fill_ptr_ff;
      scan_addr_in = scan_addr_ff;
      data_addr_in = data_addr_ff;
      hit_in = hit_ff;
      chosen_in = chosen_ff;
      pmask_in = pmask_ff;
      kbidx_in = kbidx_ff;
      done_in = done_ff;
      finish = 1'b0;
      rd_addr = idx_ff;
      mem_we = 1'b0;
      mem_wa = idx_ff;
      mem_wd = rmw.new_val;

      case (state_ff)
         ST_IDLE: begin
            rd_addr = (req_cmd == CMD_QUERY) ? start_pos : req_entry_index;
            if (accept) begin
               cmd_in = req_cmd;
               idx_in = req_entry_index;
               mask_in = req_chunk_mask;
               case (req_cmd)
                  CMD_INIT: begin
                     fill_ptr_in = '0;
                     state_in = ST_INIT;
                  end
                  CMD_QUERY: begin
                     scan_addr_in = next_addr(start_pos, entries_ff);
                     data_addr_in = start_pos;
                     state_in = (nonzero_ff == '0) ? ST_RMW : ST_SCAN;
                  end
                  default: state_in = ST_RMW;
               endcase
            end
         end
         ST_RMW: begin
            rd_addr = idx_ff;
            if (out_free) begin
               finish = 1'b1;
               mem_we = rmw.ok;
               if (rmw.ok && rmw.now_zero && (nonzero_ff != '0)) begin
                  nonzero_in = nonzero_ff - CNT_W'(1);
               end
               hit_in = rmw.ok;
               chosen_in = '0;
               pmask_in = '0;
               kbidx_in = rmw.ok ? {idx_ff, rmw.bit_sel} : '0;
               done_in = (nonzero_in == '0);
               state_in = ST_IDLE;
            end
         end
         ST_INIT: begin
            mem_we = (new_entries != '0);
            mem_wa = fill_ptr_ff[ADDR_W-1:0];
            mem_wd = (fill_ptr_ff < full_cnt) ? FULL_ENTRY : part_val;
            if (!fill_last) begin
               fill_ptr_in = fill_ptr_ff + CNT_W'(1);
            end else if (out_free) begin
               finish = 1'b1;
               entries_in = new_entries;
               nonzero_in = new_entries;
               scan_ptr_in = '0;
               hit_in = 1'b0;
               chosen_in = '0;
               pmask_in = '0;
               kbidx_in = '0;
               done_in = (new_entries == '0);
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (rd_data_ff == '0) begin
               rd_addr = scan_addr_ff;
               data_addr_in = scan_addr_ff;
               scan_addr_in = next_addr(scan_addr_ff, entries_ff);
            end else begin
               rd_addr = data_addr_ff;
               if (out_free) begin
                  finish = 1'b1;
                  scan_ptr_in = next_addr(data_addr_ff, entries_ff);
                  hit_in = 1'b1;
                  chosen_in = data_addr_ff;
                  pmask_in = rd_data_ff;
                  kbidx_in = '0;
                  done_in = (nonzero_ff == '0);
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= map_mem[rd_addr];
      if (mem_we) begin
         map_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_kb_ff <= '0;
         entries_ff <= '0;
         nonzero_ff <= '0;
         scan_ptr_ff <= '0;
         fill_ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            total_kb_ff <= csr_total_kbytes;
         end
         entries_ff <= entries_in;
         nonzero_ff <= nonzero_in;
         scan_ptr_ff <= scan_ptr_in;
         fill_ptr_ff <= fill_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      mask_ff <= mask_in;
      scan_addr_ff <= scan_addr_in;
      data_addr_ff <= data_addr_in;
      hit_ff <= hit_in;
      chosen_ff <= chosen_in;
      pmask_ff <= pmask_in;
      kbidx_ff <= kbidx_in;
      done_ff <= done_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit = hit_ff;
   assign rsp_chosen_entry = chosen_ff;
   assign rsp_pending_mask = pmask_ff;
   assign rsp_write_kb_index = kbidx_ff;
   assign rsp_all_done = done_ff;

endmodule

FILE: src/crb_rmw_unit.sv
// modify step of a receive: lowest chunk bit select, clear and accept check
module crb_rmw_unit
   import crb_pkg::*;
(
   input  logic              enable,
   input  logic [MASK_W-1:0] cur_val,
   input  logic [MASK_W-1:0] chunk_mask,
   output crb_rmw_type       result
);

   logic [BIT_W-1:0]  low_bit;
   logic [MASK_W-1:0] cleared;

   always_comb begin
      low_bit = BIT_W'(MASK_W - 1);
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (chunk_mask[i]) begin
            low_bit = BIT_W'(i);
         end
      end
   end

   assign cleared = cur_val & ~(MASK_W'(1) << low_bit);

   assign result.ok = enable && (chunk_mask != '0) && ((cur_val & chunk_mask) != '0);
   assign result.bit_sel = low_bit;
   assign result.new_val = cleared;
   assign result.now_zero = (cleared == '0);

endmodule

FILE: src/crb_checker.sv
// port-level checks of the chunk reception bitmap and their bind
module crb_checker
   import crb_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_hit,
   input logic [ADDR_W-1:0]   rsp_chosen_entry,
   input logic [MASK_W-1:0]   rsp_pending_mask,
   input logic [KB_W-1:0]     rsp_write_kb_index,
   input logic                rsp_all_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_kb_index))
      else $error("rsp word dropped or changed while stalled");

   a_kb_only_on_receive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_write_kb_index != '0) |->
         rsp_hit && (rsp_chosen_entry == '0) && (rsp_pending_mask == '0))
      else $error("kb index on a word that is not an accepted receive");

   a_query_hit_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_pending_mask != '0) |-> rsp_hit && !rsp_all_done)
      else $error("pending mask reported while map complete or no hit");

   a_mask_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |->
         (rsp_pending_mask == '0) && (rsp_chosen_entry == '0))
      else $error("entry reported without a hit");

endmodule

bind chunk_reception_bitmap_top crb_checker u_crb_checker (.*);

FILE: tb/chunk_map_checker.sv
// checker for the chunk reception bitmap: predicts every rsp_ word and compares it
module chunk_map_checker
   import crb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_total_kbytes,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [ADDR_W-1:0] req_entry_index,
   input  logic [MASK_W-1:0] req_chunk_mask,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_hit,
   input  logic [ADDR_W-1:0] rsp_chosen_entry,
   input  logic [MASK_W-1:0] rsp_pending_mask,
   input  logic [KB_W-1:0]   rsp_write_kb_index,
   input  logic              rsp_all_done,
   output int                fail_count,
   output int                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] chosen_entry;
      logic [MASK_W-1:0] pending_mask;
      logic [KB_W-1:0]   write_kb_index;
      logic              all_done;
   } chunk_result_type;

   logic [MASK_W-1:0] pend_map [MAP_ENTRIES];
   logic [ADDR_W-1:0] scan_ptr;
   logic [CNT_W-1:0]  map_used;
   logic [CNT_W-1:0]  map_live;
   logic [CSR_W-1:0]  size_kb;
   chunk_result_type  awaited_results [$];
   chunk_result_type  want;
   int                fails = 0;

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   function automatic chunk_result_type apply_map_word(input logic [CMD_W-1:0] cmd,
                                                       input logic [ADDR_W-1:0] idx,
                                                       input logic [MASK_W-1:0] mask);
      chunk_result_type  r;
      int                kb;
      int                full;
      int                rem;
      int                pos;
      int                i;
      int                b;
      logic [MASK_W-1:0] cur;
      r = '0;
      case (cmd)
         CMD_INIT: begin
            kb = (int'(size_kb) > CAP_KB) ? CAP_KB : int'(size_kb);
            full = kb / KB_PER_ENTRY;
            rem = kb % KB_PER_ENTRY;
            for (i = 0; i < full; i++)
               pend_map[i] = FULL_ENTRY;
            map_used = CNT_W'(full);
            if (rem != 0) begin
               pend_map[full] = MASK_W'((1 << rem) - 1);
               map_used = CNT_W'(full + 1);
            end
            map_live = map_used;
            scan_ptr = '0;
         end
         CMD_QUERY: begin
            pos = (scan_ptr >= map_used) ? 0 : int'(scan_ptr);
            for (i = 0; i < int'(map_used) && !r.hit; i++) begin
               if (pend_map[pos] != '0) begin
                  r.hit = 1'b1;
                  r.chosen_entry = ADDR_W'(pos);
                  r.pending_mask = pend_map[pos];
                  scan_ptr = ADDR_W'((pos + 1 >= int'(map_used)) ? 0 : pos + 1);
               end else begin
                  pos = (pos + 1 >= int'(map_used)) ? 0 : pos + 1;
               end
            end
         end
         CMD_RECV: begin
            if (idx < map_used && mask != '0 && (pend_map[idx] & mask) != '0) begin
               b = 0;
               while (!mask[b])
                  b++;
               cur = pend_map[idx];
               cur[b] = 1'b0;
               pend_map[idx] = cur;
               if (cur == '0 && map_live != '0)
                  map_live = map_live - 1'b1;
               r.hit = 1'b1;
               r.write_kb_index = {idx, BIT_W'(b)};
            end
         end
         default: ;
      endcase
      r.all_done = (map_live == '0);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         scan_ptr = '0;
         map_used = '0;
         map_live = '0;
         size_kb = '0;
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready)
            size_kb = csr_total_kbytes;
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("rsp word with no request waiting");
               fails++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  fails++;
               end
               if (rsp_chosen_entry !== want.chosen_entry) begin
                  $error("chosen_entry: expected %0d, got %0d",
                         want.chosen_entry, rsp_chosen_entry);
                  fails++;
               end
               if (rsp_pending_mask !== want.pending_mask) begin
                  $error("pending_mask: expected %0h, got %0h",
                         want.pending_mask, rsp_pending_mask);
                  fails++;
               end
               if (rsp_write_kb_index !== want.write_kb_index) begin
                  $error("write_kb_index: expected %0d, got %0d",
                         want.write_kb_index, rsp_write_kb_index);
                  fails++;
               end
               if (rsp_all_done !== want.all_done) begin
                  $error("all_done: expected %0d, got %0d", want.all_done, rsp_all_done);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready)
            awaited_results.push_back(apply_map_word(req_cmd, req_entry_index,
                                                     req_chunk_mask));
      end
      outstanding <= awaited_results.size();
      fail_count <= fails;
   end

endmodule

FILE: tb/tb_chunk_reception_bitmap_top.sv
// testbench top for the chunk reception bitmap: stimulus, flow control and verdict
module tb_chunk_reception_bitmap_top;
   import crb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 10000000;
   localparam int PHASE_WORDS = 150;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_total_kbytes = '0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [CMD_W-1:0]  req_cmd = CMD_INIT;
   logic [ADDR_W-1:0] req_entry_index = '0;
   logic [MASK_W-1:0] req_chunk_mask = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_hit;
   logic [ADDR_W-1:0] rsp_chosen_entry;
   logic [MASK_W-1:0] rsp_pending_mask;
   logic [KB_W-1:0]   rsp_write_kb_index;
   logic              rsp_all_done;

   int fail_count;
   int outstanding;
   int cycles = 0;
   int send_gap_pct = 0;
   int stall_pct = 0;
   bit hold_asked = 1'b0;

   chunk_reception_bitmap_top uut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_total_kbytes   (csr_total_kbytes),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_entry_index    (req_entry_index),
      .req_chunk_mask     (req_chunk_mask),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_chosen_entry   (rsp_chosen_entry),
      .rsp_pending_mask   (rsp_pending_mask),
      .rsp_write_kb_index (rsp_write_kb_index),
      .rsp_all_done       (rsp_all_done)
   );

   chunk_map_checker map_check (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_total_kbytes   (csr_total_kbytes),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_entry_index    (req_entry_index),
      .req_chunk_mask     (req_chunk_mask),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_chosen_entry   (rsp_chosen_entry),
      .rsp_pending_mask   (rsp_pending_mask),
      .rsp_write_kb_index (rsp_write_kb_index),
      .rsp_all_done       (rsp_all_done),
      .fail_count         (fail_count),
      .outstanding        (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_asked) begin
            hold_asked = 1'b0;
            repeat (HOLD_CYCLES) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic put_word(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] idx,
                           input logic [MASK_W-1:0] mask);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_entry_index <= idx;
      req_chunk_mask <= mask;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_transfer_size(input logic [CSR_W-1:0] kb);
      settle();
      csr_valid <= 1'b1;
      csr_total_kbytes <= kb;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ADDR_W-1:0] any_index();
      return ADDR_W'($urandom_range(0, MAP_ENTRIES - 1));
   endfunction

   function automatic logic [MASK_W-1:0] any_mask();
      return MASK_W'($urandom_range(0, 255));
   endfunction

   initial begin
      logic [CSR_W-1:0] size;
      int               kb_capped;
      int               map_n;
      int               d_entry;
      int               d_bit;
      int               ph;
      int               n;
      int               roll;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty map straight out of reset
      put_word(CMD_QUERY, '0, '0);
      put_word(CMD_RECV, '0, 8'h01);
      put_word(CMD_INIT, '0, '0);
      put_word(CMD_SPARE, '0, '0);

      // oversize transfer, clamped to the full map
      set_transfer_size(CSR_W'(16383));
      put_word(CMD_INIT, '0, '0);
      put_word(CMD_RECV, ADDR_W'(1023), 8'h80);
      put_word(CMD_RECV, '0, 8'hff);
      put_word(CMD_RECV, '0, 8'h01);
      put_word(CMD_RECV, '0, 8'h03);
      put_word(CMD_RECV, '0, 8'h00);
      put_word(CMD_RECV, ADDR_W'(1023), 8'h80);
      put_word(CMD_QUERY, '0, '0);
      put_word(CMD_QUERY, '0, '0);
      put_word(CMD_SPARE, ADDR_W'(1023), 8'hff);

      // exact multiple of an entry, scan pointer wrap
      set_transfer_size(CSR_W'(16));
      put_word(CMD_INIT, '0, '0);
      put_word(CMD_QUERY, '0, '0);
      put_word(CMD_QUERY, '0, '0);
      put_word(CMD_QUERY, '0, '0);
      put_word(CMD_RECV, ADDR_W'(2), 8'h01);

      // partial last entry
      set_transfer_size(CSR_W'(13));
      put_word(CMD_INIT, '0, '0);
      put_word(CMD_RECV, ADDR_W'(1), 8'h20);
      put_word(CMD_RECV, ADDR_W'(1), 8'h10);

      // single chunk, completes at once
      set_transfer_size(CSR_W'(1));
      put_word(CMD_INIT, '0, '0);
      put_word(CMD_RECV, '0, 8'h01);
      put_word(CMD_QUERY, '0, '0);

      for (ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 53; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 53; end
            default: begin send_gap_pct = 14; stall_pct = 14; end
         endcase
         case (ph)
            0: size = CSR_W'(8192);
            2: size = CSR_W'(16383);
            3: size = CSR_W'(8 * $urandom_range(1, 20));
            5: size = CSR_W'(8191);
            default: size = CSR_W'($urandom_range(1, 160));
         endcase
         set_transfer_size(size);
         kb_capped = (int'(size) > CAP_KB) ? CAP_KB : int'(size);
         map_n = (kb_capped + KB_PER_ENTRY - 1) / KB_PER_ENTRY;
         put_word(CMD_INIT, any_index(), any_mask());
         d_entry = 0;
         d_bit = 0;
         for (n = 0; n < PHASE_WORDS; n++) begin
            if (ph == 4 && n == PHASE_WORDS / 2)
               hold_asked = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
               if (d_entry >= map_n) begin
                  put_word(CMD_QUERY, any_index(), any_mask());
                  put_word(CMD_INIT, any_index(), any_mask());
                  d_entry = 0;
                  d_bit = 0;
               end else begin
                  // lowest set bit of the mask walks the chunks in order
                  put_word(CMD_RECV, ADDR_W'(d_entry), (any_mask() | 8'd1) << d_bit);
                  d_bit++;
                  if (d_bit == KB_PER_ENTRY) begin
                     d_bit = 0;
                     d_entry++;
                  end
               end
            end else if (roll < 75) begin
               put_word(CMD_QUERY, any_index(), any_mask());
            end else if (roll < 92) begin
               if ($urandom_range(0, 1))
                  put_word(CMD_RECV, ADDR_W'($urandom_range(0, map_n)), any_mask());
               else
                  put_word(CMD_RECV, any_index(), any_mask());
            end else if (roll < 96) begin
               put_word(CMD_INIT, any_index(), any_mask());
               d_entry = 0;
               d_bit = 0;
            end else begin
               put_word(CMD_SPARE, any_index(), any_mask());
            end
         end
      end

      settle();
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
